// ----- rtl/usm_pkg.sv -----
// ----------------------------------------------------------------------------
// usm_pkg: shared constants and types for the 5x5 unsharp mask stream
// Kernel weights, divider reciprocal, size limits and inter-module structs.
// ----------------------------------------------------------------------------
package usm_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_PIXEL_BITS = 16;

    localparam int KSIZE      = 5;
    localparam int LINES      = 4;
    localparam int SIZE_MIN   = 5;
    localparam int HEIGHT_MAX = 4096;
    localparam int ROW_W      = 12;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

    localparam int W_CENTER = 505;
    localparam int W_EDGE7  = 7;
    localparam int W_RING26 = 26;
    localparam int DIVISOR  = 273;
    localparam int OUT_MAX  = 255;
    // quotient below 256 exactly when the sum is below this bound
    localparam int SAT_LIMIT = (OUT_MAX + 1) * DIVISOR;
    localparam int QUO_W     = 17;
    // x / 273 == (x * RECIP) >> RECIP_SHIFT for all x < SAT_LIMIT
    localparam int RECIP       = 245821;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 26;

    localparam int QDEPTH = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic last;
    } front_push_t;

    typedef struct packed {
        logic       clearing;
        logic [1:0] inflight;
    } front_stat_t;

endpackage

// ----- rtl/usm_ram.sv -----
// ----------------------------------------------------------------------------
// usm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module usm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ----- rtl/usm_front.sv -----
// ----------------------------------------------------------------------------
// usm_front: pixel intake, raster counters, line stores and 5x5 window
// Accepts pixels, classifies interior centres and pushes window snapshots.
// ----------------------------------------------------------------------------
module usm_front #(
    parameter int MAX_WIDTH  = usm_pkg::DEFAULT_MAX_WIDTH,
    parameter int PIXEL_BITS = usm_pkg::DEFAULT_PIXEL_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [usm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [usm_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [PIXEL_BITS-1:0]                in_pixel,
    input  logic [$clog2(usm_pkg::QDEPTH+1)-1:0] q_count,
    output usm_pkg::front_push_t                 push,
    output logic [25*PIXEL_BITS-1:0]             window_flat,
    output usm_pkg::front_stat_t                 stat
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int PB  = PIXEL_BITS;
    localparam int RW  = usm_pkg::ROW_W;
    localparam int K   = usm_pkg::KSIZE;
    localparam int QCW = $clog2(usm_pkg::QDEPTH + 1);
    localparam int LINES_W = usm_pkg::LINES * PIXEL_BITS;
    localparam logic [CW-1:0] CLR_LAST = CW'(MAX_WIDTH - 1);

    logic [usm_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [usm_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          clearing_reg;
    logic [CW-1:0] clr_addr_reg;

    logic          f0_valid_reg, f0_emit_reg, f0_last_reg;
    logic [PB-1:0] f0_pixel_reg;
    logic [CW-1:0] f0_col_reg;
    logic [PB-1:0] win_reg [K][K];
    usm_pkg::front_push_t push_reg;

    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic          accept, emit, last;
    logic [QCW:0]  used;
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [LINES_W-1:0] ram_wdata, ram_rdata;

    // Clamp the configured sizes into their legal ranges
    always_comb
    begin
        if (32'(width_reg) < usm_pkg::SIZE_MIN)
            w_last = CW'(usm_pkg::SIZE_MIN - 1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_last = CW'(MAX_WIDTH - 1);
        else
            w_last = CW'(32'(width_reg) - 1);
        if (32'(height_reg) < usm_pkg::SIZE_MIN)
            h_last = RW'(usm_pkg::SIZE_MIN - 1);
        else if (32'(height_reg) > usm_pkg::HEIGHT_MAX)
            h_last = RW'(usm_pkg::HEIGHT_MAX - 1);
        else
            h_last = RW'(32'(height_reg) - 1);
    end

    // Credit check: every item in flight may still need a queue slot
    assign used     = (QCW + 1)'(q_count) + (QCW + 1)'(f0_valid_reg) + (QCW + 1)'(push_reg.valid);
    assign in_ready = !clearing_reg && (used < (QCW + 1)'(usm_pkg::QDEPTH));
    assign accept   = in_valid && in_ready;
    assign emit     = (row_reg >= RW'(4)) && (col_reg >= CW'(4));
    assign last     = (row_reg == h_last) && (col_reg == w_last);

    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        if (col_reg == w_last)
        begin
            col_next = '0;
            row_next = (row_reg == h_last) ? '0 : row_reg + RW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= usm_pkg::WIDTH_RESET;
            height_reg   <= usm_pkg::HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            f0_valid_reg <= 1'b0;
            push_reg     <= '0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CLR_LAST)
                    clearing_reg <= 1'b0;
            end
            if (cfg_we && cfg_index == usm_pkg::REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data[usm_pkg::WIDTH_REG_W-1:0];
                col_reg   <= '0;
                row_reg   <= '0;
            end
            else if (cfg_we && cfg_index == usm_pkg::REG_IMAGE_HEIGHT)
            begin
                height_reg <= cfg_data;
                col_reg    <= '0;
                row_reg    <= '0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            f0_valid_reg   <= accept;
            push_reg.valid <= f0_valid_reg && f0_emit_reg;
            push_reg.last  <= f0_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f0_pixel_reg <= in_pixel;
            f0_col_reg   <= col_reg;
            f0_emit_reg  <= emit;
            f0_last_reg  <= last;
        end
    end

    // Line k of the store sits at bits [k*PB +: PB], oldest line lowest
    assign ram_we    = clearing_reg || f0_valid_reg;
    assign ram_waddr = clearing_reg ? clr_addr_reg : f0_col_reg;
    assign ram_wdata = clearing_reg ? '0 : {f0_pixel_reg, ram_rdata[LINES_W-1:PB]};

    usm_ram #(
        .WIDTH (LINES_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    // Shift the window one column left and load the new column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < K; k++)
                for (int m = 0; m < K; m++)
                    win_reg[k][m] <= '0;
        end
        else if (f0_valid_reg)
        begin
            for (int k = 0; k < K; k++)
            begin
                for (int m = 0; m < K - 1; m++)
                    win_reg[k][m] <= win_reg[k][m+1];
                win_reg[k][K-1] <= (k == K - 1) ? f0_pixel_reg : ram_rdata[k*PB +: PB];
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < K; k++)
            for (int m = 0; m < K; m++)
                window_flat[(k*K+m)*PB +: PB] = win_reg[k][m];
    end

    assign push          = push_reg;
    assign stat.clearing = clearing_reg;
    assign stat.inflight = 2'(f0_valid_reg) + 2'(push_reg.valid);

endmodule

// ----- rtl/usm_queue.sv -----
// ----------------------------------------------------------------------------
// usm_queue: short FIFO of window snapshots between front and back
// Holds a window and its frame-end flag per entry.
// ----------------------------------------------------------------------------
module usm_queue #(
    parameter int WIDTH = 401
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [WIDTH-1:0]                     push_data,
    input  logic                                 pop,
    output logic                                 pop_valid,
    output logic [WIDTH-1:0]                     pop_data,
    output logic [$clog2(usm_pkg::QDEPTH+1)-1:0] count
);

    localparam int PW  = $clog2(usm_pkg::QDEPTH);
    localparam int QCW = $clog2(usm_pkg::QDEPTH + 1);

    logic [WIDTH-1:0] mem_reg [usm_pkg::QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_reg + QCW'(push) - QCW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ----- rtl/usm_back.sv -----
// ----------------------------------------------------------------------------
// usm_back: kernel arithmetic, divide by 273, clamp and output register
// Five stages that all hold together while the output beat is stalled.
// ----------------------------------------------------------------------------
module usm_back #(
    parameter int PIXEL_BITS = usm_pkg::DEFAULT_PIXEL_BITS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  logic [25*PIXEL_BITS:0]     q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_sharpened,
    output logic                       out_last
);

    localparam int PB = PIXEL_BITS;
    localparam int K  = usm_pkg::KSIZE;
    localparam int NW = PB + 9;
    localparam int PW = usm_pkg::QUO_W + usm_pkg::RECIP_W;

    logic en;
    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, b4_valid_reg, out_valid_reg;
    logic b1_last_reg, b2_last_reg, b3_last_reg, b4_last_reg, out_last_reg;

    logic [PB+1:0] s1_reg, s7_reg, s16_reg, s26_reg;
    logic [PB+2:0] s4_reg;
    logic [PB-1:0] ctr_reg;
    logic [NW-1:0] pos_reg, neg_reg;
    logic [NW:0]   diff;
    logic          b3_neg_reg, b3_big_reg, b4_neg_reg, b4_big_reg;
    logic [usm_pkg::QUO_W-1:0] x_reg;
    logic [PW-1:0] prod_reg;
    logic [7:0]    out_data_reg;
    logic [PB-1:0] px [K][K];

    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        for (int k = 0; k < K; k++)
            for (int m = 0; m < K; m++)
                px[k][m] = q_data[(k*K+m)*PB +: PB];
    end

    assign diff = {1'b0, pos_reg} - {1'b0, neg_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg  <= q_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            out_valid_reg <= b4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // group the window by kernel weight
            s1_reg  <= (PB+2)'(px[0][0]) + (PB+2)'(px[0][4]) + (PB+2)'(px[4][0])
                     + (PB+2)'(px[4][4]);
            s4_reg  <= (PB+3)'(px[0][1]) + (PB+3)'(px[0][3]) + (PB+3)'(px[1][0])
                     + (PB+3)'(px[1][4]) + (PB+3)'(px[3][0]) + (PB+3)'(px[3][4])
                     + (PB+3)'(px[4][1]) + (PB+3)'(px[4][3]);
            s7_reg  <= (PB+2)'(px[0][2]) + (PB+2)'(px[2][0]) + (PB+2)'(px[2][4])
                     + (PB+2)'(px[4][2]);
            s16_reg <= (PB+2)'(px[1][1]) + (PB+2)'(px[1][3]) + (PB+2)'(px[3][1])
                     + (PB+2)'(px[3][3]);
            s26_reg <= (PB+2)'(px[1][2]) + (PB+2)'(px[2][1]) + (PB+2)'(px[2][3])
                     + (PB+2)'(px[3][2]);
            ctr_reg <= px[2][2];
            b1_last_reg <= q_data[25*PB];

            // weight the groups: centre positive, the rest negative
            pos_reg <= NW'(ctr_reg) * NW'(usm_pkg::W_CENTER);
            neg_reg <= NW'(s1_reg) + (NW'(s4_reg) << 2) + NW'(s7_reg) * NW'(usm_pkg::W_EDGE7)
                     + (NW'(s16_reg) << 4) + NW'(s26_reg) * NW'(usm_pkg::W_RING26);
            b2_last_reg <= b1_last_reg;

            // negative sums truncate to zero or below; large ones saturate
            b3_neg_reg  <= diff[NW];
            b3_big_reg  <= !diff[NW] && (diff >= (NW+1)'(usm_pkg::SAT_LIMIT));
            x_reg       <= diff[usm_pkg::QUO_W-1:0];
            b3_last_reg <= b2_last_reg;

            prod_reg    <= PW'(x_reg) * PW'(usm_pkg::RECIP);
            b4_neg_reg  <= b3_neg_reg;
            b4_big_reg  <= b3_big_reg;
            b4_last_reg <= b3_last_reg;

            if (b4_big_reg)
                out_data_reg <= 8'(usm_pkg::OUT_MAX);
            else if (b4_neg_reg)
                out_data_reg <= '0;
            else
                out_data_reg <= prod_reg[usm_pkg::RECIP_SHIFT +: 8];
            out_last_reg <= b4_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_sharpened = out_data_reg;
    assign out_last      = out_last_reg;

endmodule

// ----- rtl/unsharp_mask_5x5_stream.sv -----
// The window a pixel beat completes passes intake, push, queue and back-end registers.
// Throughput: one pixel per cycle while credits allow, set by the 1R1W line store RAM.
// The back end stalls only when the output beat is held; the front stops via queue credits.
// Reset: asynchronous, active low; counters, window and sizes (640 x 480) return to reset.
// After reset the line store is zeroed, one column per cycle, with s_axis_tready low
// until all MAX_WIDTH columns are clear; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// unsharp_mask_5x5_stream: streaming 5x5 unsharp mask over raster frames
// Front keeps four line stores and the window; back does kernel, divide, clamp.
// ----------------------------------------------------------------------------
module unsharp_mask_5x5_stream #(
    parameter int MAX_WIDTH  = usm_pkg::DEFAULT_MAX_WIDTH,
    parameter int PIXEL_BITS = usm_pkg::DEFAULT_PIXEL_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: index 0 image_width, index 1 image_height
    input  logic                           cfg_we,
    input  logic [usm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [usm_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // [15:0] pixel
    // sharpened output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] sharpened
    output logic                           m_axis_tlast    // frame_end
);

    localparam int WIN_W = 25 * PIXEL_BITS;
    localparam int QCW   = $clog2(usm_pkg::QDEPTH + 1);

    usm_pkg::front_push_t push;
    usm_pkg::front_stat_t stat;
    logic [WIN_W-1:0] window_flat;
    logic [WIN_W:0]   q_data;
    logic             q_valid, q_pop;
    logic [QCW-1:0]   q_count;

    // Front: drop bits above PIXEL_BITS, track position, build windows
    usm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_pixel    (s_axis_tdata[PIXEL_BITS-1:0]),
        .q_count     (q_count),
        .push        (push),
        .window_flat (window_flat),
        .stat        (stat)
    );

    // Queue: hold interior windows with their frame-end flag
    usm_queue #(
        .WIDTH (WIN_W + 1)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push.valid),
        .push_data ({push.last, window_flat}),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data),
        .count     (q_count)
    );

    // Back: convolve, divide by 273, clamp and present the beat
    usm_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_sharpened (m_axis_tdata),
        .out_last      (m_axis_tlast)
    );

    // The queue never overflows: occupancy plus front items in flight fit its depth
    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(q_count) + 32'(stat.inflight)) <= usm_pkg::QDEPTH)
        else $error("queue credit exceeded");

    // No pixel is taken while the line store is being cleared
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        stat.clearing |-> !s_axis_tready)
        else $error("pixel accepted during line store clear");

    // A push into a full queue would lose a window
    a_no_full_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && !q_pop) |-> (32'(q_count) < usm_pkg::QDEPTH))
        else $error("push into full queue");

endmodule

// ----- tb/unsharp_mask_5x5_stream_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsharp_mask_5x5_stream_tb: self-checking bench for the 5x5 unsharp mask
// Streams raster frames through the block and predicts every sharpened beat
// and its frame-end flag from a behavioral copy of the line stores and window.
// It then compares each output beat with the oldest pending prediction.
// ----------------------------------------------------------------------------
module unsharp_mask_5x5_stream_tb;

    localparam int MAXW        = 2048;
    localparam int LATENCY     = 12;       // pipeline depth plus margin
    localparam int CYCLE_LIMIT = 600000;

    // register indexes past the two real registers; writes there are dropped
    localparam logic [usm_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [usm_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    // pixel content styles for random frames
    typedef enum int {FILL_LOW, FILL_FULL, FILL_FLAT, FILL_SPIKE} fill_t;

    localparam int GAUSS [5][5] = '{
        '{  -1,  -4,  -7,  -4,  -1 },
        '{  -4, -16, -26, -16,  -4 },
        '{  -7, -26, 505, -26,  -7 },
        '{  -4, -16, -26, -16,  -4 },
        '{  -1,  -4,  -7,  -4,  -1 }
    };

    typedef struct packed {
        logic [7:0] sharpened;
        logic       frame_end;
    } sharp_beat_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [usm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [usm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [15:0]                    s_axis_tdata;   // [15:0] pixel
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [7:0]                     m_axis_tdata;   // [7:0] sharpened
    logic                           m_axis_tlast;   // frame_end

    unsharp_mask_5x5_stream dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // shadow copy of the block's state
    logic [15:0]          line_mem [4][MAXW];
    logic [15:0]          win      [5][5];
    int                   col_pos;
    int                   row_pos;
    logic [11:0]          width_reg;
    logic [12:0]          height_reg;

    sharp_beat_t          pending_beats [$];
    int                   errors;
    int                   send_idle;     // percent of cycles the source holds off
    int                   recv_stall;    // percent of cycles the sink stalls
    int                   cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the shadow line stores and window by one pixel; queue a beat
    // when the window covers an interior centre.
    task automatic sharpen_predict(input logic [15:0] pix);
        int          w;
        int          h;
        int          c;
        int          r;
        int          acc;
        logic [15:0] column [5];
        sharp_beat_t beat;
        w = (width_reg < 5) ? 5 : ((width_reg > MAXW) ? MAXW : width_reg);
        h = (height_reg < 5) ? 5 : ((height_reg > 4096) ? 4096 : height_reg);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        for (int k = 0; k < 4; k++)
            column[k] = line_mem[k][c];
        column[4] = pix;
        for (int k = 0; k < 4; k++)
            line_mem[k][c] = column[k + 1];
        for (int k = 0; k < 5; k++)
        begin
            for (int m = 0; m < 4; m++)
                win[k][m] = win[k][m + 1];
            win[k][4] = column[k];
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
        if (r >= 4 && c >= 4)
        begin
            acc = 0;
            for (int k = 0; k < 5; k++)
                for (int m = 0; m < 5; m++)
                    acc += int'(win[k][m]) * GAUSS[k][m];
            acc = acc / 273;   // truncates toward zero
            if (acc > 255) acc = 255;
            if (acc < 0) acc = 0;
            beat.sharpened = acc[7:0];
            beat.frame_end = (r == h - 1) && (c == w - 1);
            pending_beats.push_back(beat);
        end
    endtask

    // Drive one pixel beat and hold it until the block takes it.
    task automatic send_pixel(input logic [15:0] pix);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sharpen_predict(pix);
    endtask

    // Wait until every predicted beat has come out, then let the pipeline empty.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [usm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [usm_pkg::CFG_DATA_W-1:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == usm_pkg::REG_IMAGE_WIDTH || idx == usm_pkg::REG_IMAGE_HEIGHT)
        begin
            if (idx == usm_pkg::REG_IMAGE_WIDTH)
                width_reg = val[11:0];
            else
                height_reg = val;
            col_pos = 0;
            row_pos = 0;
        end
    endtask

    function automatic logic [15:0] make_pixel(fill_t style, int x, int y);
        case (style)
            FILL_LOW:   return 16'($urandom_range(255));
            FILL_FLAT:  return 16'($urandom_range(3) + ((x + y) % 2) * 40);
            FILL_SPIKE: return ((x % 3) == 1 && $urandom_range(3) == 0) ? 16'hFFFF
                                                                       : 16'($urandom_range(60));
            default:    return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input int w, input int h, input fill_t style,
                              input int cut);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (cut == 0 || y * w + x < cut)
                    send_pixel(make_pixel(style, x, y));
    endtask

    // Reset sizes: the start of a 640-wide frame gives no beat at all.
    task automatic test_reset_sizes;
        for (int i = 0; i < 45; i++)
            send_pixel(16'($urandom_range(255)));
    endtask

    // Field extremes, every register, spare indexes and out-of-range sizes.
    task automatic test_directed;
        write_reg(usm_pkg::REG_IMAGE_WIDTH, 13'd5);
        write_reg(usm_pkg::REG_IMAGE_HEIGHT, 13'd5);
        for (int i = 0; i < 25; i++) send_pixel(16'hFFFF);   // saturates high
        for (int i = 0; i < 25; i++) send_pixel(16'h0000);
        for (int i = 0; i < 25; i++) send_pixel(i == 12 ? 16'hFFFF : 16'h0000);
        for (int i = 0; i < 25; i++) send_pixel(i[0] ? 16'hFFFF : 16'h0001);
        // dropped writes must not restart the frame
        send_frame(5, 2, FILL_LOW, 0);
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0000);
        send_frame(5, 3, FILL_LOW, 0);
        // widths below the minimum clamp to five
        write_reg(usm_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_reg(usm_pkg::REG_IMAGE_HEIGHT, 13'd0);
        send_frame(5, 5, FILL_FULL, 0);
        write_reg(usm_pkg::REG_IMAGE_WIDTH, 13'd4);
        write_reg(usm_pkg::REG_IMAGE_HEIGHT, 13'd6);
        send_frame(5, 6, FILL_FLAT, 0);
    endtask

    // Largest sizes through their clamps, the frames cut short.
    task automatic test_size_extremes;
        write_reg(usm_pkg::REG_IMAGE_WIDTH, 13'h1FFF);   // upper bit dropped, clamps to max
        write_reg(usm_pkg::REG_IMAGE_HEIGHT, 13'd5);
        send_frame(2048, 5, FILL_LOW, 40);
        write_reg(usm_pkg::REG_IMAGE_WIDTH, 13'd5);
        write_reg(usm_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);  // clamps to 4096 lines
        send_frame(5, 4096, FILL_SPIKE, 40);
    endtask

    // Random small frames; some are cut short by a size write.
    task automatic test_random_frames(input int idle_in, input int stall_out,
                                      input int budget, input bit hold_off);
        int sent;
        int w;
        int h;
        int cut;
        send_idle  = idle_in;
        recv_stall = stall_out;
        sent = 0;
        while (sent < budget)
        begin
            w = $urandom_range(12, 5);
            h = $urandom_range(9, 5);
            write_reg(usm_pkg::REG_IMAGE_WIDTH, 13'(w));
            write_reg(usm_pkg::REG_IMAGE_HEIGHT, 13'(h));
            cut = ($urandom_range(5) == 0) ? $urandom_range(w * h - 1, 1) : 0;
            if (hold_off && sent == 0)
            begin
                // pause mid-frame until the output side has caught up
                send_frame(w, 3, FILL_LOW, 0);
                drain();
                send_frame(w, h - 3, FILL_LOW, 0);
            end
            else
                send_frame(w, h, fill_t'($urandom_range(3)), cut);
            sent += (cut != 0) ? cut : w * h;
        end
    endtask

    // Output sink: random stalls, and check every accepted beat.
    always @(posedge clk)
    begin
        sharp_beat_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: sharpened=%0d frame_end=%0b",
                       m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_axis_tdata !== want.sharpened)
                begin
                    $error("sharpened: expected %0d, got %0d", want.sharpened, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.frame_end)
                begin
                    $error("frame_end: expected %0b, got %0b", want.frame_end, m_axis_tlast);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("unsharp_mask_5x5_stream verification failed");
            $finish;
        end
    end

    initial
    begin
        errors        = 0;
        cycles        = 0;
        send_idle     = 0;
        recv_stall    = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = usm_pkg::REG_IMAGE_WIDTH;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        width_reg     = 12'd640;
        height_reg    = 13'd480;
        col_pos       = 0;
        row_pos       = 0;
        for (int k = 0; k < 4; k++)
            for (int i = 0; i < MAXW; i++)
                line_mem[k][i] = '0;
        for (int k = 0; k < 5; k++)
            for (int m = 0; m < 5; m++)
                win[k][m] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_sizes();
        test_directed();
        test_size_extremes();
        test_random_frames(0, 0, 180, 1'b1);
        test_random_frames(86, 0, 180, 1'b0);
        test_random_frames(0, 86, 180, 1'b0);
        test_random_frames(30, 30, 180, 1'b0);
        drain();

        if (errors == 0)
            $display("unsharp_mask_5x5_stream verification clean");
        else
            $display("unsharp_mask_5x5_stream verification failed");
        $finish;
    end

endmodule

// ----- unsharp_mask_5x5_stream.f -----
rtl/usm_pkg.sv
rtl/usm_ram.sv
rtl/usm_front.sv
rtl/usm_queue.sv
rtl/usm_back.sv
rtl/unsharp_mask_5x5_stream.sv
tb/unsharp_mask_5x5_stream_tb.sv
